// File: rtl/core/cpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and codes for the chunked packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int LEN_W       = 32;
    localparam logic [LEN_W-1:0] LEN_MASK = LEN_W'({LENGTH_BITS{1'b1}});

    // configuration register indexes
    localparam logic [1:0] CFG_CHUNK_BYTES = 2'd0;
    localparam logic [1:0] CFG_CHECKSUM    = 2'd1;
    localparam logic [1:0] CFG_CHUNKED     = 2'd2;

    localparam logic [31:0] CHUNK_BYTES_RST = 32'h0002_0000;

    // parser phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_CK_LEN   = 3'd1;
    localparam logic [2:0] PH_CK_DATA  = 3'd2;
    localparam logic [2:0] PH_SIZE_LEN = 3'd3;
    localparam logic [2:0] PH_PAYLOAD  = 3'd4;
    localparam logic [2:0] PH_CONTROL  = 3'd5;
    localparam logic [2:0] PH_MSG_LEN  = 3'd6;
    localparam logic [2:0] PH_MSG_DATA = 3'd7;

    // result kinds
    localparam logic [2:0] KIND_CHECKSUM = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
    localparam logic [2:0] KIND_EMPTY    = 3'd2;
    localparam logic [2:0] KIND_INTR     = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // control byte codes
    localparam logic [7:0] CTL_KEEP_GOING = 8'd0;
    localparam logic [7:0] CTL_INTERRUPT  = 8'd1;
    localparam logic [7:0] CTL_MESSAGE    = 8'd2;

    typedef struct packed {
        logic [31:0] chunk_bytes;
        logic        checksum_enabled;
        logic        chunked_mode;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

// File: rtl/core/chunked_packet_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_packet_deframer_unit
// Splits a received byte stream into checksum, payload and status items.
// ----------------------------------------------------------------------------
// s_axis carries one received byte per item. m_axis carries at most one
// result per byte: tuser is the kind (checksum byte, payload byte, empty
// packet, interrupted, protocol error), tdata the byte (zero for status
// kinds), tlast marks the final byte of a checksum field or packet. Length
// prefixes other than a zero packet size, keep-going and message control
// bytes and discarded messages give no output. Registers are written through
// i_cfg_we / i_cfg_index / i_cfg_wdata; the user must do so only while no
// packet is in flight, which the block itself does not enforce.
// A byte lands in the input register; a compare-and-count parse step then
// fills the output register that drives tvalid. One byte per cycle is taken
// sustained while m_axis accepts results. Reset (synchronous, active low)
// empties both registers, returns the parser to idle and loads register
// defaults. When m_axis stalls the output register holds, the input register
// fills if empty, and s_axis_tready stays low until the output drains.
// ----------------------------------------------------------------------------
module chunked_packet_deframer_unit
    import cpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       step;
    logic       out_free;
    t_result    parse_res;
    t_result    out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunk_bytes      <= CHUNK_BYTES_RST;
            r_cfg.checksum_enabled <= 1'b0;
            r_cfg.chunked_mode     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHUNK_BYTES: r_cfg.chunk_bytes      <= i_cfg_wdata;
                CFG_CHECKSUM:    r_cfg.checksum_enabled <= i_cfg_wdata[0];
                CFG_CHUNKED:     r_cfg.chunked_mode     <= i_cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    cpd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (parse_res)
    );

    cpd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_result (parse_res),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_result (out_res)
    );

    assign m_axis_tvalid = out_res.valid;
    assign m_axis_tdata  = out_res.data;
    assign m_axis_tuser  = out_res.kind;
    assign m_axis_tlast  = out_res.last;

endmodule

// File: rtl/core/cpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_parser
// Framing state and per-byte parse step; state advances on i_step.
// ----------------------------------------------------------------------------
module cpd_parser
    import cpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    logic [2:0]       r_phase, n_phase;
    logic [1:0]       r_pcnt, n_pcnt;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0] r_total, n_total;
    logic [LEN_W-1:0] r_offset, n_offset;
    logic [LEN_W-1:0] r_chunk_rem, n_chunk_rem;
    logic [LEN_W-1:0] r_field_rem, n_field_rem;

    logic [2:0]       eff_phase;
    logic [1:0]       eff_pcnt;
    logic [LEN_W-1:0] eff_acc;
    logic [LEN_W-1:0] acc_sh;
    logic [LEN_W-1:0] acc_len;
    logic             pfx_done;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] cs;
    logic [LEN_W-1:0] chunk_len;
    logic [LEN_W-1:0] off_inc;
    logic [LEN_W-1:0] crem_dec;
    logic [LEN_W-1:0] frem_dec;
    t_result          res;

    // an idle block starts a new packet with this byte
    assign eff_phase = (r_phase == PH_IDLE) ?
                       (i_cfg.checksum_enabled ? PH_CK_LEN : PH_SIZE_LEN) : r_phase;
    assign eff_pcnt  = (r_phase == PH_IDLE) ? 2'd0 : r_pcnt;
    assign eff_acc   = (r_phase == PH_IDLE) ? '0 : r_acc;

    assign acc_sh   = {eff_acc[LEN_W-9:0], i_byte};
    assign acc_len  = acc_sh & LEN_MASK;
    assign pfx_done = (eff_pcnt == 2'd3);

    // size of the next chunk; a size prefix starts the payload at offset zero
    assign left      = (eff_phase == PH_SIZE_LEN) ? acc_len : (r_total - r_offset);
    assign cs        = (i_cfg.chunk_bytes == '0) ? LEN_W'(1) : i_cfg.chunk_bytes;
    assign chunk_len = (!i_cfg.chunked_mode || left < cs) ? left : cs;

    assign off_inc  = r_offset + LEN_W'(1);
    assign crem_dec = (r_chunk_rem != '0) ? r_chunk_rem - LEN_W'(1) : r_chunk_rem;
    assign frem_dec = r_field_rem - LEN_W'(1);

    always_comb begin
        n_phase     = eff_phase;
        n_pcnt      = eff_pcnt;
        n_acc       = eff_acc;
        n_total     = r_total;
        n_offset    = r_offset;
        n_chunk_rem = r_chunk_rem;
        n_field_rem = r_field_rem;
        res         = '0;
        case (eff_phase)
            PH_CK_LEN, PH_SIZE_LEN, PH_MSG_LEN: begin
                n_acc  = acc_sh;
                n_pcnt = pfx_done ? 2'd0 : eff_pcnt + 2'd1;
                if (pfx_done) begin
                    n_acc = acc_len;
                    if (eff_phase == PH_CK_LEN) begin
                        n_field_rem = acc_len;
                        if (acc_len == '0) begin
                            n_phase = PH_SIZE_LEN;
                            n_acc   = '0;
                        end else begin
                            n_phase = PH_CK_DATA;
                        end
                    end else if (eff_phase == PH_SIZE_LEN) begin
                        n_total  = acc_len;
                        n_offset = '0;
                        if (acc_len == '0) begin
                            n_phase    = PH_IDLE;
                            res.valid  = 1'b1;
                            res.kind   = KIND_EMPTY;
                            res.last   = 1'b1;
                        end else begin
                            n_phase     = PH_PAYLOAD;
                            n_chunk_rem = chunk_len;
                        end
                    end else begin
                        n_field_rem = acc_len;
                        n_phase     = (acc_len != '0) ? PH_MSG_DATA : PH_CONTROL;
                    end
                end
            end
            PH_CK_DATA: begin
                n_field_rem = frem_dec;
                res.valid   = 1'b1;
                res.kind    = KIND_CHECKSUM;
                res.data    = i_byte;
                if (frem_dec == '0) begin
                    n_phase  = PH_SIZE_LEN;
                    n_pcnt   = 2'd0;
                    n_acc    = '0;
                    res.last = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_offset    = off_inc;
                n_chunk_rem = crem_dec;
                res.valid   = 1'b1;
                res.kind    = KIND_PAYLOAD;
                res.data    = i_byte;
                if (off_inc >= r_total) begin
                    n_phase  = PH_IDLE;
                    n_pcnt   = 2'd0;
                    res.last = 1'b1;
                end else if (crem_dec == '0) begin
                    n_phase = PH_CONTROL;
                end
            end
            PH_CONTROL: begin
                case (i_byte)
                    CTL_KEEP_GOING: begin
                        n_phase     = PH_PAYLOAD;
                        n_chunk_rem = chunk_len;
                    end
                    CTL_INTERRUPT: begin
                        n_phase   = PH_IDLE;
                        n_pcnt    = 2'd0;
                        res.valid = 1'b1;
                        res.kind  = KIND_INTR;
                    end
                    CTL_MESSAGE: begin
                        n_phase = PH_MSG_LEN;
                        n_pcnt  = 2'd0;
                        n_acc   = '0;
                    end
                    default: begin
                        n_phase   = PH_IDLE;
                        n_pcnt    = 2'd0;
                        res.valid = 1'b1;
                        res.kind  = KIND_ERROR;
                    end
                endcase
            end
            PH_MSG_DATA: begin
                n_field_rem = frem_dec;
                if (frem_dec == '0) begin
                    n_phase = PH_CONTROL;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_pcnt  = 2'd0;
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pcnt      <= 2'd0;
            r_acc       <= '0;
            r_total     <= '0;
            r_offset    <= '0;
            r_chunk_rem <= '0;
            r_field_rem <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pcnt      <= n_pcnt;
            r_acc       <= n_acc;
            r_total     <= n_total;
            r_offset    <= n_offset;
            r_chunk_rem <= n_chunk_rem;
            r_field_rem <= n_field_rem;
        end
    end

`ifndef ASSERT_OFF
    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.valid && res.last &&
        (res.kind == KIND_PAYLOAD || res.kind == KIND_EMPTY) |=> r_phase == PH_IDLE)
        else $error("packet end did not return to idle");

    a_control_chunk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CONTROL |-> r_chunk_rem == '0)
        else $error("control phase with chunk bytes left");

    a_payload_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_offset < r_total)
        else $error("payload phase past packet end");

    a_prefix_count_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt != 2'd0 |->
        (r_phase == PH_CK_LEN || r_phase == PH_SIZE_LEN || r_phase == PH_MSG_LEN))
        else $error("prefix count outside a length field");
`endif

endmodule

// File: rtl/core/cpd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_out_reg
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module cpd_out_reg
    import cpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output t_result o_result
);

    logic       r_valid;
    logic [2:0] r_kind;
    logic [7:0] r_data;
    logic       r_last;

    // register can take a new result when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_step && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_step && i_result.valid) begin
            r_kind <= i_result.kind;
            r_data <= i_result.data;
            r_last <= i_result.last;
        end
    end

    assign o_result = '{valid: r_valid, kind: r_kind, data: r_data, last: r_last};

endmodule
